@@ design/abm_pkg.sv @@
// Shared types and constants for the audio block monitor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package abm_pkg;

  // Store size default, in samples per bank
  localparam int unsigned MAX_BLOCK_DEF = 1024;

  // Field widths
  localparam int unsigned SAMPLE_W = 17;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned BLEN_W   = 11;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned JUMP_W   = 17;
  // Wide enough to compare an index with the largest store size
  localparam int unsigned CMP_W    = 13;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 1'd1;

  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST     = 11'd240;
  localparam logic [THR_W-1:0]  DETECT_THRESHOLD_RST = 15'd1638;

  // Unity in sample units
  localparam logic [SAMPLE_W-1:0] UNITY = 17'd32767;
  localparam logic [IDX_W-1:0]    IDX_MAX = 11'd2047;

  // Per-beat control from the index tracker to the evaluation stage
  typedef struct packed {
    logic first;      // index zero: match restarts from have_prev
    logic have_prev;  // a full block is in the other bank
    logic in_range;   // index below block length and store size
    logic len_eq;     // index + 1 equals block length
  } abm_ctrl_t;

  // One result beat
  typedef struct packed {
    logic                repeated;
    logic [CNT_W-1:0]    rep_count;
    logic [POS_W-1:0]    det_pos;
    logic                det_valid;
    logic [JUMP_W-1:0]   max_jump;
    logic [CNT_W-1:0]    range_count;
  } abm_result_t;

endpackage

@@ design/audio_block_monitor.sv @@
// Top level of the audio block monitor: ports, configuration registers
// and the store / tracker / evaluation pipeline. Depends on abm_pkg,
// abm_store, abm_seq and abm_eval.
//
//   channel  direction  handshake         contents
//   s_*      in         tvalid/tready     tdata: sample, sample_position; tlast
//   m_*      out        tvalid/tready     tdata: counters, jump, detect; tuser
//   cfg_*    in         cfg_we            cfg_index selects, cfg_data value
//
// One sample per cycle when not stalled; results pass stage one, then the result register.
// The store is written at accept and read at accept through a registered port;
// a bank only turns into the read bank after its last write, so no access
// of one beat meets a write still in flight.
// A stall on m_tready holds the whole pipe; s_tready follows it.
// Reset (synchronous) clears counters, index, banks and valid flags;
// the store contents are not cleared.
`timescale 1ns / 1ps

module audio_block_monitor #(
  parameter int unsigned MAX_BLOCK = abm_pkg::MAX_BLOCK_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input beat
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [55:0]                        s_tdata,  // sample[16:0], sample_position[48:17], zero
  input  logic                               s_tlast,  // last_in_block
  // Result beat
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [119:0]                       m_tdata,  // out_of_range_count[31:0],
                                                       // peak_jump[48:32],
                                                       // detected_valid[49],
                                                       // detected_position[81:50],
                                                       // repeated_block_count[113:82], zero
  output logic                               m_tuser,  // block_repeated
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [abm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import abm_pkg::*;

  localparam int unsigned AW = $clog2(2 * MAX_BLOCK);

  logic [BLEN_W-1:0]   block_length;
  logic [THR_W-1:0]    detect_threshold;

  logic                en;
  logic                accept;
  logic [SAMPLE_W-1:0] sample;
  logic [POS_W-1:0]    sample_position;
  logic                store_we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [SAMPLE_W-1:0] rdata;
  abm_ctrl_t           ctrl;
  abm_result_t         result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length     <= BLOCK_LENGTH_RST;
      detect_threshold <= DETECT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:     block_length     <= cfg_data[BLEN_W-1:0];
        REG_DETECT_THRESHOLD: detect_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe whenever the result slot is free or drains
  assign en              = !m_tvalid || m_tready;
  assign s_tready        = en;
  assign accept          = s_tvalid && en;
  assign sample          = s_tdata[SAMPLE_W-1:0];
  assign sample_position = s_tdata[SAMPLE_W+POS_W-1:SAMPLE_W];

  abm_seq #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .last         (s_tlast),
    .block_length (block_length),
    .store_we     (store_we),
    .waddr        (waddr),
    .raddr        (raddr),
    .ctrl         (ctrl)
  );

  abm_store #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr),
    .wdata (sample),
    .re    (en),
    .raddr (raddr),
    .rdata (rdata)
  );

  abm_eval u_eval (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .accept           (accept),
    .sample           (sample),
    .sample_position  (sample_position),
    .last             (s_tlast),
    .ctrl             (ctrl),
    .rdata            (rdata),
    .detect_threshold (detect_threshold),
    .out_valid        (m_tvalid),
    .result           (result)
  );

  // Pack the result beat
  assign m_tdata = {6'b0, result.rep_count, result.det_pos, result.det_valid,
                    result.max_jump, result.range_count};
  assign m_tuser = result.repeated;

`ifndef ASSERT_OFF
  // A repeat flag comes with a nonzero repeat count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> result.rep_count != '0)
    else $error("repeat flagged with zero repeat count");

  // No detected position before detection
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.det_valid |-> result.det_pos == '0)
    else $error("detected position set without detection");

  // Detection stays latched across beats
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && result.det_valid |=> result.det_valid)
    else $error("detection dropped");

  // Store writes only come with an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    store_we |-> accept)
    else $error("store written without an accepted beat");
`endif

endmodule

@@ design/abm_store.sv @@
// Double-banked sample store: one write port, one registered read port.
// Depends on abm_pkg.
`timescale 1ns / 1ps

module abm_store #(
  parameter int unsigned MAX_BLOCK = abm_pkg::MAX_BLOCK_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(2*MAX_BLOCK)-1:0]       waddr,
  input  logic [abm_pkg::SAMPLE_W-1:0]         wdata,
  input  logic                                 re,
  input  logic [$clog2(2*MAX_BLOCK)-1:0]       raddr,
  output logic [abm_pkg::SAMPLE_W-1:0]         rdata
);
  import abm_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_BLOCK;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Write the current beat's sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the other bank through a registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/abm_seq.sv @@
// Block index and bank tracker: forms store addresses and per-beat control.
// Depends on abm_pkg.
`timescale 1ns / 1ps

module abm_seq #(
  parameter int unsigned MAX_BLOCK = abm_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              last,
  input  logic [abm_pkg::BLEN_W-1:0]        block_length,
  output logic                              store_we,
  output logic [$clog2(2*MAX_BLOCK)-1:0]    waddr,
  output logic [$clog2(2*MAX_BLOCK)-1:0]    raddr,
  output abm_pkg::abm_ctrl_t                ctrl
);
  import abm_pkg::*;

  localparam int unsigned AW = $clog2(2 * MAX_BLOCK);
  localparam logic [AW-1:0] BANK_OFS = AW'(MAX_BLOCK);

  logic [IDX_W-1:0] idx;
  logic             bank;
  logic             have_prev;

  logic [IDX_W-1:0] idx_next;
  logic             bank_next;
  logic             have_prev_next;
  logic             in_store;
  logic [AW-1:0]    idx_addr;

  // Decode the current index
  always_comb begin
    in_store       = {{(CMP_W-IDX_W){1'b0}}, idx} < CMP_W'(MAX_BLOCK);
    ctrl.first     = (idx == '0);
    ctrl.have_prev = have_prev;
    ctrl.in_range  = in_store && (idx < block_length);
    ctrl.len_eq    = ({1'b0, idx} + (IDX_W+1)'(1)) == {1'b0, block_length};
  end

  // Active bank takes the write, the other bank is read back
  always_comb begin
    idx_addr = AW'(idx);
    store_we = accept && in_store;
    waddr    = bank ? idx_addr + BANK_OFS : idx_addr;
    raddr    = bank ? idx_addr : idx_addr + BANK_OFS;
  end

  // Advance index (held at IDX_MAX), restart it on last; flip bank at the end of a full-length block
  always_comb begin
    idx_next       = idx;
    bank_next      = bank;
    have_prev_next = have_prev;
    if (accept) begin
      if (last) begin
        idx_next = '0;
        if (ctrl.len_eq) begin
          bank_next      = ~bank;
          have_prev_next = 1'b1;
        end
      end else if (idx != IDX_MAX) begin
        idx_next = idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      bank      <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      idx       <= idx_next;
      bank      <= bank_next;
      have_prev <= have_prev_next;
    end
  end

endmodule

@@ design/abm_eval.sv @@
// Evaluation stage and result register: compares with the stored block,
// updates counters, jump and detection, and holds the result beat.
// Depends on abm_pkg.
`timescale 1ns / 1ps

module abm_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           accept,
  input  logic [abm_pkg::SAMPLE_W-1:0]   sample,
  input  logic [abm_pkg::POS_W-1:0]      sample_position,
  input  logic                           last,
  input  abm_pkg::abm_ctrl_t             ctrl,
  input  logic [abm_pkg::SAMPLE_W-1:0]   rdata,
  input  logic [abm_pkg::THR_W-1:0]      detect_threshold,
  output logic                           out_valid,
  output abm_pkg::abm_result_t           result
);
  import abm_pkg::*;

  // Stage one payload
  logic                v1;
  logic [SAMPLE_W-1:0] s1;
  logic [POS_W-1:0]    pos1;
  logic                last1;
  abm_ctrl_t           ctrl1;

  // Running state
  logic                matching;
  logic [SAMPLE_W-1:0] prior;
  logic [CNT_W-1:0]    range_count;
  logic [JUMP_W-1:0]   max_jump;
  logic                det_valid;
  logic [POS_W-1:0]    det_pos;
  logic [CNT_W-1:0]    rep_count;

  logic                matching_next;
  logic [CNT_W-1:0]    range_count_next;
  logic [JUMP_W-1:0]   max_jump_next;
  logic                det_valid_next;
  logic [POS_W-1:0]    det_pos_next;
  logic [CNT_W-1:0]    rep_count_next;
  logic                repeated;

  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   diff_abs;
  logic                match_now;

  // Capture the accepted beat; read data arrives alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1    <= sample;
      pos1  <= sample_position;
      last1 <= last;
      ctrl1 <= ctrl;
    end
  end

  // Compute next running state for the beat in stage one
  always_comb begin
    mag      = s1[SAMPLE_W-1] ? -s1 : s1;
    diff     = {s1[SAMPLE_W-1], s1} - {prior[SAMPLE_W-1], prior};
    diff_abs = diff[SAMPLE_W] ? -diff : diff;

    match_now     = (ctrl1.first ? ctrl1.have_prev : matching)
                    && ctrl1.in_range && (rdata == s1);
    repeated      = last1 && ctrl1.len_eq && match_now;
    matching_next = last1 ? 1'b0 : match_now;

    range_count_next = range_count;
    if (mag > UNITY && range_count != '1) begin
      range_count_next = range_count + CNT_W'(1);
    end

    max_jump_next = max_jump;
    if (!ctrl1.first && diff_abs[JUMP_W-1:0] > max_jump) begin
      max_jump_next = diff_abs[JUMP_W-1:0];
    end

    det_valid_next = det_valid;
    det_pos_next   = det_pos;
    if (!det_valid && mag >= {{(SAMPLE_W-THR_W){1'b0}}, detect_threshold}) begin
      det_valid_next = 1'b1;
      det_pos_next   = pos1;
    end

    rep_count_next = rep_count;
    if (repeated && rep_count != '1) begin
      rep_count_next = rep_count + CNT_W'(1);
    end
  end

  // Commit state when the beat leaves stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      matching    <= 1'b0;
      prior       <= '0;
      range_count <= '0;
      max_jump    <= '0;
      det_valid   <= 1'b0;
      det_pos     <= '0;
      rep_count   <= '0;
    end else if (en && v1) begin
      matching    <= matching_next;
      prior       <= s1;
      range_count <= range_count_next;
      max_jump    <= max_jump_next;
      det_valid   <= det_valid_next;
      det_pos     <= det_pos_next;
      rep_count   <= rep_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      result.range_count <= range_count_next;
      result.max_jump    <= max_jump_next;
      result.det_valid   <= det_valid_next;
      result.det_pos     <= det_pos_next;
      result.rep_count   <= rep_count_next;
      result.repeated    <= repeated;
    end
  end

endmodule
